// ===== src/assert_macros.svh =====
// Assertion macros used by the binary_max_heap RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/bmh_pkg.sv =====
// Package: codes, field widths and types for the max-heap priority queue
package bmh_pkg;

    localparam int KEY_FIELD_W   = 32;
    localparam int COUNT_FIELD_W = 7;
    localparam int OUT_DATA_W    = 48;

    typedef logic [1:0] status_t;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

endpackage

// ===== src/bmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bmh_cmp.sv =====
// Shared key comparator: strict greater-than, signed or unsigned
module bmh_cmp #(
    parameter int W = 32
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         is_signed,
    output logic         gt
);

    logic [W-1:0] a_biased;
    logic [W-1:0] b_biased;
    logic [W-1:0] sign_mask;

    assign sign_mask = {is_signed, {(W-1){1'b0}}};
    assign a_biased  = a ^ sign_mask;
    assign b_biased  = b ^ sign_mask;
    assign gt        = a_biased > b_biased;

endmodule

// ===== src/binary_max_heap.sv =====
// Top level: max-heap priority queue with a sequencer over one RAM and one comparator
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------------
//  s_*     | in        | tuser: operation; tdata: key
//  m_*     | out       | tdata: removed_key, status, entry_count, is_empty, is_full
//  cfg_*   | in        | cfg_data: key_signed
//
//  s_tready stays low from accept until the result is issued, so items go one at a time;
//  insert climbs from the new leaf, reading and comparing the parent at each level and
//  moving it down while the key is greater; remove reads the root, reads and loads the last
//  entry, then per level reads and compares the children and moves; refused items finish.
//  Reset clears count, compare mode and control; the RAM needs no clearing pass.
//  A result that cannot leave holds its item in the finish state.
`include "assert_macros.svh"

module binary_max_heap #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bmh_pkg::KEY_FIELD_W-1:0]    s_tdata,   // [31:0] key
    input  logic                               s_tuser,   // [0] operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] removed_key, [33:32] status, [40:34] entry_count,
    // [41] is_empty, [42] is_full, [47:43] zero
    output logic [bmh_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data   // [0] key_signed
);

    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_U_RD   = 4'd1;
    localparam logic [3:0] S_U_CMP  = 4'd2;
    localparam logic [3:0] S_R_ROOT = 4'd3;
    localparam logic [3:0] S_R_LAST = 4'd4;
    localparam logic [3:0] S_R_LOAD = 4'd5;
    localparam logic [3:0] S_D_RDL  = 4'd6;
    localparam logic [3:0] S_D_CMPL = 4'd7;
    localparam logic [3:0] S_D_CMPR = 4'd8;
    localparam logic [3:0] S_D_MOVE = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 key_signed_reg, key_signed_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [KEY_WIDTH-1:0] cur_reg, cur_next;
    logic [KEY_WIDTH-1:0] best_val_reg, best_val_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic [KEY_WIDTH-1:0] removed_reg, removed_next;
    status_t              status_reg, status_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic [KEY_WIDTH-1:0] cmp_a;
    logic [KEY_WIDTH-1:0] cmp_b;
    logic                 cmp_gt;

    logic [KEY_WIDTH+KEY_FIELD_W-1:0]    key_wide;
    logic [KEY_WIDTH-1:0]                key_in;
    logic [KEY_WIDTH+KEY_FIELD_W-1:0]    removed_wide;
    logic [CW+COUNT_FIELD_W-1:0]         count_wide;
    logic [IW-1:0]                       left_idx;
    logic [IW-1:0]                       right_idx;
    logic [IW-1:0]                       count_ext;
    logic [AW-1:0]                       pos_m1;
    logic [AW-1:0]                       parent_idx;
    logic [CW-1:0]                       count_m1;
    logic                                s_accept;
    logic                                out_free;
    logic                                out_refused;
    logic                                full_insert;

    assign key_wide     = {{KEY_WIDTH{1'b0}}, s_tdata};
    assign key_in       = key_wide[KEY_WIDTH-1:0];
    assign removed_wide = {{KEY_FIELD_W{1'b0}}, removed_reg};
    assign count_wide   = {{COUNT_FIELD_W{1'b0}}, count_reg};

    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign count_ext  = {{(IW-CW){1'b0}}, count_reg};
    assign pos_m1     = pos_reg - AW'(1);
    assign parent_idx = pos_m1 >> 1;
    assign count_m1   = count_reg - CW'(1);

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign out_refused = m_tvalid_reg && (m_tdata_reg[33:32] != ST_DONE);
    assign full_insert = s_accept && (s_tuser == OP_INSERT) && (count_reg == CAP_CNT);

    assign cmp_a = (state_reg == S_U_CMP) ? cur_reg : ram_rdata;
    assign cmp_b = (state_reg == S_U_CMP) ? ram_rdata : best_val_reg;

    bmh_cmp #(
        .W(KEY_WIDTH)
    ) u_cmp (
        .a         (cmp_a),
        .b         (cmp_b),
        .is_signed (key_signed_reg),
        .gt        (cmp_gt)
    );

    bmh_ram #(
        .WIDTH(KEY_WIDTH),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        key_signed_next = cfg_valid ? cfg_data : key_signed_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        removed_next    = removed_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = cur_reg;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    removed_next = '0;
                    status_next  = ST_DONE;
                    if (s_tuser == OP_INSERT)
                    begin
                        if (count_reg == CAP_CNT)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cur_next   = key_in;
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = S_U_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_R_ROOT;
                    end
                end
            end
            S_U_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_raddr  = parent_idx;
                    state_next = S_U_CMP;
                end
            end
            S_U_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_gt)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = S_U_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_R_ROOT:
            begin
                ram_raddr  = '0;
                state_next = S_R_LAST;
            end
            S_R_LAST:
            begin
                removed_next = ram_rdata;
                ram_raddr    = count_m1[AW-1:0];
                state_next   = S_R_LOAD;
            end
            S_R_LOAD:
            begin
                cur_next   = ram_rdata;
                count_next = count_m1;
                pos_next   = '0;
                state_next = S_D_RDL;
            end
            S_D_RDL:
            begin
                if (left_idx < count_ext)
                begin
                    ram_raddr     = left_idx[AW-1:0];
                    best_val_next = cur_reg;
                    best_idx_next = pos_reg;
                    state_next    = S_D_CMPL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_D_CMPL:
            begin
                if (cmp_gt)
                begin
                    best_val_next = ram_rdata;
                    best_idx_next = left_idx[AW-1:0];
                end
                if (right_idx < count_ext)
                begin
                    ram_raddr  = right_idx[AW-1:0];
                    state_next = S_D_CMPR;
                end
                else
                begin
                    state_next = S_D_MOVE;
                end
            end
            S_D_CMPR:
            begin
                if (cmp_gt)
                begin
                    best_val_next = ram_rdata;
                    best_idx_next = right_idx[AW-1:0];
                end
                state_next = S_D_MOVE;
            end
            S_D_MOVE:
            begin
                ram_we = 1'b1;
                if (best_idx_reg == pos_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_wdata  = best_val_reg;
                    pos_next   = best_idx_reg;
                    state_next = S_D_RDL;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0,
                                     count_reg == CAP_CNT,
                                     count_reg == '0,
                                     count_wide[COUNT_FIELD_W-1:0],
                                     status_reg,
                                     removed_wide[KEY_FIELD_W-1:0]};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            key_signed_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            key_signed_reg <= key_signed_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg  <= m_tdata_next;
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
    end

    `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CAP_CNT)
    `ASSERT_IMP(a_write_busy, clk, rst_n, ram_we, state_reg != S_IDLE && state_reg != S_FINISH)
    `ASSERT_IMP(a_refused_zero, clk, rst_n, out_refused, m_tdata_reg[31:0] == '0)
    `ASSERT_NEXT(a_full_refuse, clk, rst_n, full_insert, count_reg == CAP_CNT && state_reg == S_FINISH)

endmodule
